>>> hw/rtl/composed_substitution_cipher_unit_macros.svh
// Assertion macros for the composed substitution cipher unit.
`ifndef COMPOSED_SUBSTITUTION_CIPHER_UNIT_MACROS_SVH
`define COMPOSED_SUBSTITUTION_CIPHER_UNIT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define CSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/csc_pkg.sv
// Types and constants shared by the composed substitution cipher unit.
package csc_pkg;

  localparam logic [1:0] CMD_SHIFT = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_APPLY = 2'd2;
  localparam logic [1:0] CMD_TEXT  = 2'd3;

  localparam logic [7:0] LC_A = 8'h61;
  localparam logic [7:0] LC_Z = 8'h7a;
  localparam logic [7:0] UC_A = 8'h41;
  localparam logic [7:0] UC_Z = 8'h5a;

  typedef struct packed {
    logic [1:0]         command;
    logic               decrypt;
    logic signed [15:0] shift_amount;
    logic [4:0]         map_index;
    logic [4:0]         map_letter;
    logic [7:0]         in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_letter;
  } out_item_t;

  typedef struct packed {
    logic tab_re;
    logic tab_we;
    logic stg_re;
    logic stg_we;
    logic inv_re;
    logic inv_we;
  } mem_ctrl_t;

endpackage

>>> hw/rtl/composed_substitution_cipher_unit.sv
// Top level of the composed substitution cipher unit: command sequencer and output register.
// A text byte is accepted with a table read, then makes one pass through the mod-add unit,
// and waits in S_TEXT while the output register holds an untaken result; a shift command
// or a map load reduces the amount or letter one bit per cycle through the shared mod-add
// unit; an apply-map command walks each table entry in turn, paced by the single read port
// of each table and the one mod-add unit, and a decrypt first builds the inverse map.
// in_ready is low while a command is in progress. A result waits in the output register
// without blocking the next transfer in.
`include "composed_substitution_cipher_unit_macros.svh"

module composed_substitution_cipher_unit #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  csc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output csc_pkg::out_item_t out_data
);

  import csc_pkg::*;

  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam logic [AW-1:0] LAST = AW'(ALPHABET_SIZE - 1);
  localparam logic [AW-1:0] CORR = AW'(32768 % ALPHABET_SIZE);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_TEXT    = 4'd1;
  localparam logic [3:0] S_RED     = 4'd2;
  localparam logic [3:0] S_CORR    = 4'd3;
  localparam logic [3:0] S_PEND    = 4'd4;
  localparam logic [3:0] S_LOAD    = 4'd5;
  localparam logic [3:0] S_CLR     = 4'd6;
  localparam logic [3:0] S_INV_RD  = 4'd7;
  localparam logic [3:0] S_INV_WR  = 4'd8;
  localparam logic [3:0] S_TAB_RD  = 4'd9;
  localparam logic [3:0] S_TAB_MAP = 4'd10;
  localparam logic [3:0] S_TAB_WR  = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] pend_r, pend_nxt;
  logic [AW-1:0] rem_r, rem_nxt;
  logic [14:0]   opnd_r, opnd_nxt;
  logic          b15_r, b15_nxt;
  logic          dec_r, dec_nxt;
  logic          load_r, load_nxt;
  logic [4:0]    idx_r, idx_nxt;
  logic [3:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          letter_r, letter_nxt;
  logic          inrng_r, inrng_nxt;
  logic          lower_r, lower_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  mem_ctrl_t     ctrl;
  logic [AW-1:0] tab_raddr, tab_wdata, tab_rdata;
  logic [AW-1:0] stg_raddr, stg_waddr, stg_wdata, stg_rdata;
  logic [AW-1:0] inv_raddr, inv_waddr, inv_wdata, inv_rdata;
  logic [AW-1:0] alu_a, alu_b, alu_y;
  logic          alu_cin, alu_sub;

  logic          in_fire;
  logic          is_lower, is_upper;
  logic [7:0]    pos8;
  logic          pos_ok;

  csc_modadd #(.N(ALPHABET_SIZE), .AW(AW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .cin (alu_cin),
    .sub (alu_sub),
    .y   (alu_y)
  );

  csc_tables #(.N(ALPHABET_SIZE), .AW(AW)) u_tables (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .tab_raddr (tab_raddr),
    .tab_waddr (k_r),
    .tab_wdata (tab_wdata),
    .tab_rdata (tab_rdata),
    .stg_raddr (stg_raddr),
    .stg_waddr (stg_waddr),
    .stg_wdata (stg_wdata),
    .stg_rdata (stg_rdata),
    .inv_raddr (inv_raddr),
    .inv_waddr (inv_waddr),
    .inv_wdata (inv_wdata),
    .inv_rdata (inv_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    is_lower = (in_data.in_byte >= LC_A) && (in_data.in_byte <= LC_Z);
    is_upper = (in_data.in_byte >= UC_A) && (in_data.in_byte <= UC_Z);
    pos8     = in_data.in_byte - (is_lower ? LC_A : UC_A);
    pos_ok   = (is_lower || is_upper) && (pos8 < 8'(ALPHABET_SIZE));
  end

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    rem_nxt       = rem_r;
    opnd_nxt      = opnd_r;
    b15_nxt       = b15_r;
    dec_nxt       = dec_r;
    load_nxt      = load_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    byte_nxt      = byte_r;
    letter_nxt    = letter_r;
    inrng_nxt     = inrng_r;
    lower_nxt     = lower_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    ctrl      = '0;
    tab_raddr = k_r;
    tab_wdata = dec_r ? inv_rdata : stg_rdata;
    stg_raddr = k_r;
    stg_waddr = idx_r[AW-1:0];
    stg_wdata = rem_r;
    inv_raddr = alu_y;
    inv_waddr = k_r;
    inv_wdata = '0;
    alu_a     = '0;
    alu_b     = '0;
    alu_cin   = 1'b0;
    alu_sub   = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        tab_raddr = pos_ok ? pos8[AW-1:0] : '0;
        if (in_fire) begin
          dec_nxt = in_data.decrypt;
          rem_nxt = '0;
          cnt_nxt = '0;
          k_nxt   = '0;
          case (in_data.command)
            CMD_SHIFT: begin
              opnd_nxt  = in_data.shift_amount[14:0];
              b15_nxt   = in_data.shift_amount[15];
              load_nxt  = 1'b0;
              state_nxt = S_RED;
            end
            CMD_LOAD: begin
              opnd_nxt  = 15'(in_data.map_letter);
              idx_nxt   = in_data.map_index;
              load_nxt  = 1'b1;
              state_nxt = S_RED;
            end
            CMD_APPLY: begin
              state_nxt = in_data.decrypt ? S_CLR : S_TAB_RD;
            end
            default: begin
              ctrl.tab_re = 1'b1;
              byte_nxt    = in_data.in_byte;
              letter_nxt  = is_lower || is_upper;
              inrng_nxt   = pos_ok;
              lower_nxt   = is_lower;
              state_nxt   = S_TEXT;
            end
          endcase
        end
      end
      S_TEXT: begin
        alu_a = tab_rdata;
        alu_b = pend_r;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.was_letter = letter_r;
          out_data_nxt.out_byte   = inrng_r ? (lower_r ? LC_A : UC_A) + 8'(alu_y) : byte_r;
          state_nxt               = S_IDLE;
        end
      end
      S_RED: begin
        alu_a    = rem_r;
        alu_b    = rem_r;
        alu_cin  = opnd_r[14];
        rem_nxt  = alu_y;
        opnd_nxt = {opnd_r[13:0], 1'b0};
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd14) begin
          state_nxt = load_r ? S_LOAD : S_CORR;
        end
      end
      S_CORR: begin
        alu_a     = rem_r;
        alu_b     = b15_r ? CORR : '0;
        alu_sub   = 1'b1;
        rem_nxt   = alu_y;
        state_nxt = S_PEND;
      end
      S_PEND: begin
        alu_a     = pend_r;
        alu_b     = rem_r;
        alu_sub   = dec_r;
        pend_nxt  = alu_y;
        state_nxt = S_IDLE;
      end
      S_LOAD: begin
        ctrl.stg_we = (idx_r < 5'(ALPHABET_SIZE));
        state_nxt   = S_IDLE;
      end
      S_CLR: begin
        ctrl.inv_we = 1'b1;
        if (k_r == LAST) begin
          k_nxt     = '0;
          state_nxt = S_INV_RD;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_INV_RD: begin
        ctrl.stg_re = 1'b1;
        state_nxt   = S_INV_WR;
      end
      S_INV_WR: begin
        ctrl.inv_we = (stg_rdata <= LAST);
        inv_waddr   = stg_rdata;
        inv_wdata   = k_r;
        if (k_r == LAST) begin
          k_nxt     = '0;
          state_nxt = S_TAB_RD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_INV_RD;
        end
      end
      S_TAB_RD: begin
        ctrl.tab_re = 1'b1;
        state_nxt   = S_TAB_MAP;
      end
      S_TAB_MAP: begin
        alu_a       = tab_rdata;
        alu_b       = pend_r;
        stg_raddr   = alu_y;
        ctrl.stg_re = !dec_r;
        ctrl.inv_re = dec_r;
        state_nxt   = S_TAB_WR;
      end
      S_TAB_WR: begin
        ctrl.tab_we = 1'b1;
        if (k_r == LAST) begin
          pend_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_TAB_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    opnd_r     <= opnd_nxt;
    b15_r      <= b15_nxt;
    dec_r      <= dec_nxt;
    load_r     <= load_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    byte_r     <= byte_nxt;
    letter_r   <= letter_nxt;
    inrng_r    <= inrng_nxt;
    lower_r    <= lower_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CSC_ASSERT_NOW(a_pend_range, 1'b1, pend_r <= LAST, "pending shift out of range")
  `CSC_ASSERT_NEXT(a_no_result_cmd, in_fire && (in_data.command != CMD_TEXT), !$rose(out_valid_r), "result raised by a non-text command")
  `CSC_ASSERT_NEXT(a_apply_clears, (state_r == S_TAB_WR) && (k_r == LAST), (pend_r == '0) && (state_r == S_IDLE), "pending shift not cleared after apply")
  `CSC_ASSERT_NOW(a_nonletter_pass, out_valid_r && !out_data_r.was_letter, !((out_data_r.out_byte >= LC_A) && (out_data_r.out_byte <= LC_Z)) && !((out_data_r.out_byte >= UC_A) && (out_data_r.out_byte <= UC_Z)), "non-letter result is a letter")

endmodule

>>> hw/rtl/csc_modadd.sv
// Shared modular add/subtract unit over the alphabet.
module csc_modadd #(
  parameter int N  = 26,
  parameter int AW = $clog2(N)
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  input  logic          cin,
  input  logic          sub,
  output logic [AW-1:0] y
);

  localparam logic [AW+1:0] NC = (AW+2)'(N);

  logic [AW+1:0] ax;
  logic [AW+1:0] bx;
  logic [AW+1:0] sum;
  logic [AW+1:0] diff;
  logic [AW+1:0] res;

  always_comb begin
    ax   = {2'b00, a};
    bx   = {2'b00, b};
    sum  = ax + bx + (AW+2)'(cin);
    diff = ax - bx;
    if (sub) begin
      res = diff[AW+1] ? diff + NC : diff;
    end else begin
      res = (sum >= NC) ? sum - NC : sum;
    end
    y = res[AW-1:0];
  end

endmodule

>>> hw/rtl/csc_tables.sv
// Letter table, staging map and inverse scratch memories with registered reads.
module csc_tables #(
  parameter int N  = 26,
  parameter int AW = $clog2(N)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  csc_pkg::mem_ctrl_t ctrl,
  input  logic [AW-1:0]     tab_raddr,
  input  logic [AW-1:0]     tab_waddr,
  input  logic [AW-1:0]     tab_wdata,
  output logic [AW-1:0]     tab_rdata,
  input  logic [AW-1:0]     stg_raddr,
  input  logic [AW-1:0]     stg_waddr,
  input  logic [AW-1:0]     stg_wdata,
  output logic [AW-1:0]     stg_rdata,
  input  logic [AW-1:0]     inv_raddr,
  input  logic [AW-1:0]     inv_waddr,
  input  logic [AW-1:0]     inv_wdata,
  output logic [AW-1:0]     inv_rdata
);

  import csc_pkg::*;

  logic [AW-1:0] tab_mem [N];
  logic [AW-1:0] stg_mem [N];
  logic [AW-1:0] inv_mem [N];
  logic [N-1:0]  tab_vld_r;
  logic [AW-1:0] tab_rdata_r;
  logic [AW-1:0] stg_rdata_r;
  logic [AW-1:0] inv_rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_vld_r <= '0;
    end else if (ctrl.tab_we) begin
      tab_vld_r[tab_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (ctrl.stg_we) begin
      stg_mem[stg_waddr] <= stg_wdata;
    end
    if (ctrl.inv_we) begin
      inv_mem[inv_waddr] <= inv_wdata;
    end
  end

  // Unwritten table entries read as identity.
  always_ff @(posedge clk) begin
    if (ctrl.tab_re) begin
      tab_rdata_r <= tab_vld_r[tab_raddr] ? tab_mem[tab_raddr] : tab_raddr;
    end
    if (ctrl.stg_re) begin
      stg_rdata_r <= stg_mem[stg_raddr];
    end
    if (ctrl.inv_re) begin
      inv_rdata_r <= inv_mem[inv_raddr];
    end
  end

  assign tab_rdata = tab_rdata_r;
  assign stg_rdata = stg_rdata_r;
  assign inv_rdata = inv_rdata_r;

endmodule

>>> bench/tb_composed_substitution_cipher_unit.sv
// Self-checking testbench for the composed substitution cipher unit.
module tb_composed_substitution_cipher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import csc_pkg::*;

  localparam int ALPHA    = 26;
  localparam int SETTLE   = 200;
  localparam int DRAIN    = 4000;
  localparam int PHASE_SZ = 460;
  localparam int MAX_SHOW = 60;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  composed_substitution_cipher_unit #(
    .ALPHABET_SIZE(ALPHA)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  in_item_t  cmd_backlog[$];
  out_item_t cipher_bytes_due[$];

  logic [4:0] key_tab [ALPHA];
  logic [4:0] stage_map [ALPHA];
  logic [4:0] carry_shift;

  logic [ALPHA-1:0] stage_written;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int queued_cnt      = 0;
  int taken_cnt       = 0;
  int checked_cnt     = 0;
  int apply_cnt       = 0;
  int error_cnt       = 0;

  task automatic report_mismatch(input string msg);
    error_cnt++;
    if (error_cnt <= MAX_SHOW) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic encipher_item(input in_item_t it);
    int amt;
    int pos;
    logic [7:0] base;
    logic [4:0] inv [ALPHA];
    out_item_t res;
    case (it.command)
      CMD_SHIFT: begin
        amt = int'(it.shift_amount) % ALPHA;
        if (amt < 0) amt += ALPHA;
        if (it.decrypt) carry_shift = 5'((int'(carry_shift) + ALPHA - amt) % ALPHA);
        else carry_shift = 5'((int'(carry_shift) + amt) % ALPHA);
      end
      CMD_LOAD: begin
        if (it.map_index < ALPHA) stage_map[it.map_index] = 5'(int'(it.map_letter) % ALPHA);
      end
      CMD_APPLY: begin
        for (int k = 0; k < ALPHA; k++) begin
          key_tab[k] = 5'((int'(key_tab[k]) + int'(carry_shift)) % ALPHA);
        end
        carry_shift = '0;
        if (it.decrypt) begin
          for (int k = 0; k < ALPHA; k++) inv[k] = '0;
          for (int k = 0; k < ALPHA; k++) inv[int'(stage_map[k]) % ALPHA] = 5'(k);
          for (int k = 0; k < ALPHA; k++) key_tab[k] = inv[int'(key_tab[k]) % ALPHA];
        end else begin
          for (int k = 0; k < ALPHA; k++) begin
            key_tab[k] = 5'(int'(stage_map[int'(key_tab[k]) % ALPHA]) % ALPHA);
          end
        end
      end
      default: begin
        res.out_byte   = it.in_byte;
        res.was_letter = 1'b0;
        base = '0;
        if (it.in_byte >= LC_A && it.in_byte <= LC_Z) begin
          base = LC_A;
          res.was_letter = 1'b1;
        end else if (it.in_byte >= UC_A && it.in_byte <= UC_Z) begin
          base = UC_A;
          res.was_letter = 1'b1;
        end
        if (res.was_letter) begin
          pos = int'(it.in_byte) - int'(base);
          if (pos < ALPHA) begin
            res.out_byte = base + 8'((int'(key_tab[pos]) + int'(carry_shift)) % ALPHA);
          end
        end
        cipher_bytes_due.push_back(res);
      end
    endcase
  endtask

  // Driver: hold the item until its transfer, then offer the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        encipher_item(in_data);
        taken_cnt++;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= cmd_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest expected byte.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (cipher_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h", out_data.out_byte));
        end else begin
          want = cipher_bytes_due.pop_front();
          checked_cnt++;
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_data.out_byte, want.out_byte));
          if (out_data.was_letter !== want.was_letter)
            report_mismatch($sformatf("was_letter %b, expected %b",
                                      out_data.was_letter, want.was_letter));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t noise_item(input logic [1:0] cmd);
    logic [63:0] raw;
    in_item_t it;
    raw = {$urandom(), $urandom()};
    it = raw[$bits(in_item_t)-1:0];
    it.command = cmd;
    return it;
  endfunction

  task automatic queue_item(input in_item_t it);
    if (it.command == CMD_LOAD && it.map_index < ALPHA) stage_written[it.map_index] = 1'b1;
    if (it.command == CMD_APPLY) apply_cnt++;
    cmd_backlog.push_back(it);
    queued_cnt++;
  endtask

  task automatic queue_text(input logic [7:0] ch);
    in_item_t it;
    it = noise_item(CMD_TEXT);
    it.in_byte = ch;
    queue_item(it);
  endtask

  task automatic queue_shift(input logic dec, input logic [15:0] amt);
    in_item_t it;
    it = noise_item(CMD_SHIFT);
    it.decrypt = dec;
    it.shift_amount = amt;
    queue_item(it);
  endtask

  task automatic queue_load(input logic [4:0] idx, input logic [4:0] letter);
    in_item_t it;
    it = noise_item(CMD_LOAD);
    it.map_index = idx;
    it.map_letter = letter;
    queue_item(it);
  endtask

  task automatic queue_apply(input logic dec);
    in_item_t it;
    it = noise_item(CMD_APPLY);
    it.decrypt = dec;
    queue_item(it);
  endtask

  task automatic queue_full_map(input bit as_perm);
    int perm [ALPHA];
    int j;
    int tmp;
    for (int k = 0; k < ALPHA; k++) perm[k] = k;
    for (int k = ALPHA - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = perm[k];
      perm[k] = perm[j];
      perm[j] = tmp;
    end
    for (int k = 0; k < ALPHA; k++) begin
      queue_load(5'(k), as_perm ? 5'(perm[k]) : 5'($urandom_range(0, 31)));
    end
  endtask

  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return LC_A + 8'($urandom_range(0, 25));
    if (sel < 65) return UC_A + 8'($urandom_range(0, 25));
    if (sel < 75) begin
      case ($urandom_range(0, 7))
        0: return LC_A - 8'd1;
        1: return LC_Z + 8'd1;
        2: return UC_A - 8'd1;
        3: return UC_Z + 8'd1;
        4: return LC_Z;
        5: return UC_A;
        6: return 8'h00;
        default: return 8'hff;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_amount();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 60) - 30);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_random_run();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      n = $urandom_range(1, 12);
      repeat (n) queue_text(pick_char());
    end else if (sel < 64) begin
      queue_shift(1'($urandom_range(0, 1)), pick_amount());
      queue_text(pick_char());
    end else if (sel < 76) begin
      queue_load(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
    end else if (sel < 86 || !(&stage_written)) begin
      queue_full_map($urandom_range(0, 3) != 0);
      queue_apply(1'($urandom_range(0, 1)));
      n = $urandom_range(2, 8);
      repeat (n) queue_text(pick_char());
    end else begin
      queue_apply(1'($urandom_range(0, 1)));
      queue_text(pick_char());
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() > 0 || in_valid) @(posedge clk);
    for (int c = 0; c < DRAIN && cipher_bytes_due.size() > 0; c++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int idle_mode [4];
    int stall_mode [4];
    int goal;
    idle_mode  = '{0, 57, 0, 30};
    stall_mode = '{0, 0, 57, 30};
    for (int k = 0; k < ALPHA; k++) begin
      key_tab[k] = 5'(k);
      stage_map[k] = '0;
    end
    carry_shift = '0;
    stage_written = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_text(8'h00);
    queue_text(8'hff);
    queue_text(UC_A);
    queue_text(UC_Z);
    queue_text(LC_A);
    queue_text(LC_Z);
    queue_text(UC_A - 8'd1);
    queue_text(UC_Z + 8'd1);
    queue_text(LC_A - 8'd1);
    queue_text(LC_Z + 8'd1);
    queue_shift(1'b0, 16'h7fff);
    queue_text(LC_A + 8'd12);
    queue_shift(1'b0, 16'h8000);
    queue_shift(1'b1, 16'hffff);
    queue_shift(1'b1, 16'd26);
    queue_text(UC_A + 8'd16);
    queue_load(5'd31, 5'd5);
    queue_load(5'd26, 5'd0);
    queue_load(5'd0, 5'd31);
    queue_load(5'd25, 5'd26);
    queue_text(LC_A + 8'd10);
    queue_text(LC_A + 8'd10);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_mode[ph];
      recv_stall_pct  = stall_mode[ph];
      goal = queued_cnt + PHASE_SZ;
      if (ph == 0) begin
        queue_full_map(1'b0);
        queue_apply(1'b1);
        repeat (6) queue_text(pick_char());
        queue_full_map(1'b1);
        queue_apply(1'b1);
        queue_shift(1'b0, 16'd3);
        queue_apply(1'b0);
        repeat (6) queue_text(pick_char());
      end
      while (queued_cnt < goal) queue_random_run();
      wait_drained();
    end

    foreach (cipher_bytes_due[i]) begin
      report_mismatch($sformatf("expected byte %02h never arrived", cipher_bytes_due[i].out_byte));
    end
    $display("Run covered %0d transfers in (%0d map applies) and %0d result bytes checked,",
             taken_cnt, apply_cnt, checked_cnt);
    $display("across free-running, sender-idle, receiver-stall and mixed phases; %0d errors.",
             error_cnt);
    if (error_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", cipher_bytes_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/csc_pkg.sv
hw/rtl/csc_modadd.sv
hw/rtl/csc_tables.sv
hw/rtl/composed_substitution_cipher_unit.sv
bench/tb_composed_substitution_cipher_unit.sv
